[design/keyed_cache_oldest_eviction_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the keyed cache
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_CACHE_OLDEST_EVICTION_ASSERT_SVH
`define KEYED_CACHE_OLDEST_EVICTION_ASSERT_SVH

// same-cycle implication
`define KCOE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KCOE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/kcoe_pkg.sv]
// ----------------------------------------------------------------------------
// kcoe_pkg
// Types and constants shared by the keyed cache modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcoe_pkg;

  localparam int CFG_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int KEY_W   = 32;
  localparam int HANDLE_W = 32;
  localparam int SIZE_W  = 24;
  localparam int STAMP_W = 48;
  localparam int TOTAL_W = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle_in;
    logic [SIZE_W-1:0]   entry_bytes;
    logic [STAMP_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] handle_out;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
    logic [SLOT_W-1:0]   slot;
    logic [TOTAL_W-1:0]  memory_used;
    logic [TOTAL_W-1:0]  hit_total;
    logic [TOTAL_W-1:0]  miss_total;
  } out_item_t;

  // one stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  // outcome of one scan
  typedef struct packed {
    logic hit;         // key present
    logic vict_ok;     // a slot can take a new entry
    logic vict_evict;  // that slot holds a valid entry
  } scan_flags_t;

endpackage

`default_nettype wire

[design/kcoe_ram.sv]
// ----------------------------------------------------------------------------
// kcoe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcoe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/kcoe_scan.sv]
// ----------------------------------------------------------------------------
// kcoe_scan
// Per-entry scan unit: tracks key match, first free slot and oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcoe_scan #(
  parameter int ENTRIES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic                        eval_en_i,
  input  wire logic [$clog2(ENTRIES)-1:0]  eval_idx_i,
  input  wire logic                        eval_valid_i,
  input  wire kcoe_pkg::entry_t            entry_i,
  input  wire logic [kcoe_pkg::KEY_W-1:0]  key_i,
  output      kcoe_pkg::scan_flags_t       flags_o,
  output      logic [$clog2(ENTRIES)-1:0]  hit_idx_o,
  output      kcoe_pkg::entry_t            hit_entry_o,
  output      logic [$clog2(ENTRIES)-1:0]  vict_idx_o,
  output      kcoe_pkg::entry_t            vict_entry_o
);

  import kcoe_pkg::*;

  localparam int AW = $clog2(ENTRIES);

  logic          found_q, inv_q, old_q;
  logic [AW-1:0] hit_idx_q, inv_idx_q, old_idx_q;
  entry_t        hit_entry_q, old_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      inv_q   <= 1'b0;
      old_q   <= 1'b0;
    end else if (start_i) begin
      found_q <= 1'b0;
      inv_q   <= 1'b0;
      old_q   <= 1'b0;
    end else if (eval_en_i) begin
      if (eval_valid_i && (entry_i.key == key_i) && !found_q) begin
        found_q <= 1'b1;
      end
      if (!eval_valid_i && !inv_q) begin
        inv_q <= 1'b1;
      end
      if (eval_valid_i && !inv_q && (!old_q || (entry_i.stamp < old_entry_q.stamp))) begin
        old_q <= 1'b1;
      end
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk_i) begin
    if (eval_en_i && !start_i) begin
      if (eval_valid_i && (entry_i.key == key_i) && !found_q) begin
        hit_idx_q   <= eval_idx_i;
        hit_entry_q <= entry_i;
      end
      if (!eval_valid_i && !inv_q) begin
        inv_idx_q <= eval_idx_i;
      end
      // strict compare keeps the lowest index on equal stamps
      if (eval_valid_i && !inv_q && (!old_q || (entry_i.stamp < old_entry_q.stamp))) begin
        old_idx_q   <= eval_idx_i;
        old_entry_q <= entry_i;
      end
    end
  end

  assign flags_o.hit        = found_q;
  assign flags_o.vict_ok    = inv_q | old_q;
  assign flags_o.vict_evict = !inv_q & old_q;
  assign hit_idx_o          = hit_idx_q;
  assign hit_entry_o        = hit_entry_q;
  assign vict_idx_o         = inv_q ? inv_idx_q : old_idx_q;
  assign vict_entry_o       = old_entry_q;

endmodule

`default_nettype wire

[design/keyed_cache_oldest_eviction.sv]
// ----------------------------------------------------------------------------
// keyed_cache_oldest_eviction
// Fully associative keyed table with oldest-stamp replacement.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one lookup,
// add or clear per transfer. Output channel (out_valid_o / out_stall_i /
// out_data_o) returns exactly one result per input transfer, in order.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
// entries_in_use register; write it only while the block is idle.
//
// Entry data lives in one RAM read one entry per cycle. A lookup, or an add
// with a nonzero handle, with n = min(entries_in_use, ENTRIES) > 0 reads n
// entries in the scan state, then passes the drain and finish states; other
// items go from idle straight to finish. The next item is taken only once
// the block is back in idle after finishing the last one.
// Reset clears all valid bits, the byte total and both counters at once;
// items are taken from the first cycle after reset. A stalled result stays
// in the output register while the next item is already scanned; the block
// finishes that item only once the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_cache_oldest_eviction_assert.svh"

module keyed_cache_oldest_eviction #(
  parameter int ENTRIES = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire kcoe_pkg::in_item_t          in_data_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      kcoe_pkg::out_item_t         out_data_o,
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [kcoe_pkg::CFG_W-1:0]  cfg_data_i
);

  import kcoe_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_e;

  state_e              state_q, state_d;
  in_item_t            op_q, op_d;
  logic [CW-1:0]       n_q, n_d;
  logic [CW-1:0]       issue_cnt_q, issue_cnt_d;
  logic                rd_vld_q;
  logic [AW-1:0]       eval_idx_q;
  logic [ENTRIES-1:0]  valid_q, valid_d;
  logic [TOTAL_W-1:0]  bytes_q, bytes_d;
  logic [TOTAL_W-1:0]  hits_q, hits_d;
  logic [TOTAL_W-1:0]  misses_q, misses_d;
  logic [CFG_W-1:0]    cfg_q;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                in_fire, fin_fire, do_scan;
  logic [CW-1:0]       n_active;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  entry_t              ram_wdata, ram_rdata;
  scan_flags_t         flags;
  logic [AW-1:0]       hit_idx, vict_idx;
  entry_t              hit_entry, vict_entry;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign fin_fire    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (32'(cfg_q) > ENTRIES) begin
      n_active = CW'(ENTRIES);
    end else begin
      n_active = CW'(cfg_q);
    end
  end

  assign do_scan = ((in_data_i.mode == MODE_LOOKUP) ||
                    ((in_data_i.mode == MODE_ADD) && (in_data_i.handle_in != '0))) &&
                   (n_active != '0);

  kcoe_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (state_q == ST_SCAN),
    .raddr_i (issue_cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  kcoe_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_fire),
    .eval_en_i    (rd_vld_q),
    .eval_idx_i   (eval_idx_q),
    .eval_valid_i (valid_q[eval_idx_q]),
    .entry_i      (ram_rdata),
    .key_i        (op_q.key),
    .flags_o      (flags),
    .hit_idx_o    (hit_idx),
    .hit_entry_o  (hit_entry),
    .vict_idx_o   (vict_idx),
    .vict_entry_o (vict_entry)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    n_d         = n_q;
    issue_cnt_d = issue_cnt_q;
    valid_d     = valid_q;
    bytes_d     = bytes_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx;
    ram_wdata   = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d        = in_data_i;
          n_d         = n_active;
          issue_cnt_d = '0;
          state_d     = do_scan ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        issue_cnt_d = issue_cnt_q + CW'(1);
        if (issue_cnt_q == n_q - CW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (fin_fire) begin
          out_d = '0;
          case (op_q.mode)
            MODE_LOOKUP: begin
              if (flags.hit) begin
                hits_d             = hits_q + TOTAL_W'(1);
                out_d.hit          = 1'b1;
                out_d.handle_out   = hit_entry.handle;
                out_d.slot         = SLOT_W'(hit_idx);
                // refresh the stamp, keep the rest of the entry
                ram_we             = 1'b1;
                ram_waddr          = hit_idx;
                ram_wdata          = hit_entry;
                ram_wdata.stamp    = op_q.now_ms;
              end else begin
                misses_d = misses_q + TOTAL_W'(1);
              end
            end
            MODE_ADD: begin
              if (op_q.handle_in != '0) begin
                if (flags.hit) begin
                  out_d.hit  = 1'b1;
                  out_d.slot = SLOT_W'(hit_idx);
                end else if (flags.vict_ok) begin
                  bytes_d = bytes_q + TOTAL_W'(op_q.entry_bytes);
                  if (flags.vict_evict) begin
                    out_d.evicted        = 1'b1;
                    out_d.evicted_handle = vict_entry.handle;
                    bytes_d = bytes_q + TOTAL_W'(op_q.entry_bytes)
                              - TOTAL_W'(vict_entry.size);
                  end
                  valid_d[vict_idx] = 1'b1;
                  ram_we            = 1'b1;
                  ram_waddr         = vict_idx;
                  ram_wdata.key     = op_q.key;
                  ram_wdata.handle  = op_q.handle_in;
                  ram_wdata.size    = op_q.entry_bytes;
                  ram_wdata.stamp   = op_q.now_ms;
                  out_d.slot        = SLOT_W'(vict_idx);
                end
              end
            end
            MODE_CLEAR: begin
              valid_d = '0;
              bytes_d = '0;
            end
            default: begin
            end
          endcase
          out_d.memory_used = bytes_d;
          out_d.hit_total   = hits_d;
          out_d.miss_total  = misses_d;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= '0;
      n_q         <= '0;
      issue_cnt_q <= '0;
      rd_vld_q    <= 1'b0;
      eval_idx_q  <= '0;
      valid_q     <= '0;
      bytes_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      n_q         <= n_d;
      issue_cnt_q <= issue_cnt_d;
      rd_vld_q    <= (state_q == ST_SCAN);
      eval_idx_q  <= issue_cnt_q[AW-1:0];
      valid_q     <= valid_d;
      bytes_q     <= bytes_d;
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `KCOE_ASSERT_NEXT(a_busy_after_transfer, in_fire, in_stall_o,
                    "block took a transfer but did not go busy")
  `KCOE_ASSERT_NOW(a_scan_in_range, state_q == ST_SCAN, issue_cnt_q < n_q,
                   "scan address ran past the entries in use")
  `KCOE_ASSERT_NEXT(a_clear_empties, fin_fire && (op_q.mode == MODE_CLEAR),
                    (valid_q == '0) && (bytes_q == '0),
                    "clear left valid entries or bytes behind")
  `KCOE_ASSERT_NOW(a_hit_no_evict, out_valid_o,
                   !(out_data_o.hit && out_data_o.evicted),
                   "result reports both a hit and an eviction")

endmodule

`default_nettype wire
